// File: hw/rtl/tss_pkg.sv
// Shared constants, types and the vertex order table of the triangle span block.
`default_nettype none
package tss_pkg;

   localparam int C_BITS     = 16;                  // vertex coordinate width
   localparam int S_BITS     = 12;                  // screen coordinate width
   localparam int REG_BITS   = S_BITS + 1;          // width of the screen registers
   localparam int Q_BITS     = C_BITS;              // quotient bits of the edge division
   localparam int N_BITS     = 2 * C_BITS + 2;      // dividend width
   localparam int D_BITS     = C_BITS + 1;          // divisor width
   localparam int X_BITS     = ((C_BITS > S_BITS) ? C_BITS : S_BITS) + 3;
   localparam int COLOR_BITS = 32;

   localparam logic [REG_BITS-1:0] SCREEN_LIM = REG_BITS'(1) << S_BITS;
   localparam logic [REG_BITS-1:0] WIDTH_RST  = REG_BITS'(640);
   localparam logic [REG_BITS-1:0] HEIGHT_RST = REG_BITS'(480);

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   // Data that travels beside both edge divisions.
   typedef struct packed {
      logic [S_BITS-1:0]     row;
      logic [COLOR_BITS-1:0] color;
      logic                  hit;
      logic                  neg1;
      logic                  neg2;
      logic [C_BITS-1:0]     base1;
      logic [C_BITS-1:0]     base2;
   } side_type;

   // Returns {high, middle, low} vertex indices for the three strict y compares.
   function automatic logic [5:0] order_lookup(input logic [2:0] sel);
      logic [5:0] res;
      unique case (sel)
         3'd0:    res = {2'd2, 2'd1, 2'd0};
         3'd1:    res = {2'd1, 2'd2, 2'd0};
         3'd3:    res = {2'd1, 2'd0, 2'd2};
         3'd4:    res = {2'd2, 2'd0, 2'd1};
         3'd6:    res = {2'd0, 2'd2, 2'd1};
         3'd7:    res = {2'd0, 2'd1, 2'd2};
         default: res = {2'd0, 2'd0, 2'd0};
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tss_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tss_divider
   import tss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [N_BITS-1:0] num_in,
   input  wire logic [D_BITS-1:0] den_in,
   output logic      [Q_BITS-1:0] quo_out
);

   logic [N_BITS-1:0] rem_ff [Q_BITS];
   logic [D_BITS-1:0] den_ff [Q_BITS];
   logic [Q_BITS-1:0] quo_ff [Q_BITS];

   genvar i;
   generate
      for (i = 0; i < Q_BITS; i++) begin : g_step
         logic [N_BITS-1:0] rem_prev;
         logic [D_BITS-1:0] den_prev;
         logic [Q_BITS-1:0] quo_prev;
         logic [N_BITS-1:0] dsh;
         logic              take;

         if (i == 0) begin : g_first
            assign rem_prev = num_in;
            assign den_prev = den_in;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign den_prev = den_ff[i-1];
            assign quo_prev = quo_ff[i-1];
         end

         assign dsh  = N_BITS'(den_prev) << (Q_BITS - 1 - i);
         assign take = (rem_prev >= dsh);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= take ? (rem_prev - dsh) : rem_prev;
               den_ff[i] <= den_prev;
               quo_ff[i] <= {quo_prev[Q_BITS-2:0], take};
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[Q_BITS-1];

endmodule
`default_nettype wire

// File: hw/rtl/triangle_scanline_span.sv
// Top level: sorts the vertices, divides along both edges and clips one span per row.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------------
//  req_     | tvalid/tready       | tdata: vert0..2 x/y, row, fill_color
//  rsp_     | tvalid/tready       | tdata: row, start, end, color; tuser: valid
//  csr_     | we (no wait)        | index, wdata: screen_width, screen_height
//
// One transaction is accepted per cycle while not stalled; the result passes through
// four setup stages, sixteen single-bit division stages and the output register.
// Reset (synchronous) clears the valid bits and loads width 640 and height 480.
// A stall on rsp_tready freezes the whole pipeline and deasserts req_tready.
`default_nettype none
module triangle_scanline_span
   import tss_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, row, fill_color, zero pad
   input  wire logic [143:0]   req_tdata,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // span_row, span_start, span_end, span_color, zero pad
   output logic [71:0]         rsp_tdata,
   // span_valid
   output logic [0:0]          rsp_tuser,
   input  wire logic           csr_we,
   input  wire logic [0:0]     csr_index,
   input  wire logic [REG_BITS-1:0] csr_wdata
);

   logic [REG_BITS-1:0] width_ff, height_ff;
   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage A: sort the vertices by y.
   logic signed [C_BITS-1:0] vx [3];
   logic signed [C_BITS-1:0] vy [3];
   logic [5:0] ord;
   logic [2:0] sel;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vx[k] = req_tdata[2*k*C_BITS +: C_BITS];
         vy[k] = req_tdata[(2*k+1)*C_BITS +: C_BITS];
      end
      sel = {vy[0] > vy[1], vy[0] > vy[2], vy[1] > vy[2]};
      ord = order_lookup(sel);
   end

   logic va_ff;
   logic signed [C_BITS-1:0] lx_ff, ly_ff, mx_ff, my_ff, hx_ff, hy_ff;
   logic [S_BITS-1:0]     ra_ff;
   logic [COLOR_BITS-1:0] ca_ff;

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff <= vx[ord[1:0]];
         ly_ff <= vy[ord[1:0]];
         mx_ff <= vx[ord[3:2]];
         my_ff <= vy[ord[3:2]];
         hx_ff <= vx[ord[5:4]];
         hy_ff <= vy[ord[5:4]];
         ra_ff <= req_tdata[6*C_BITS +: S_BITS];
         ca_ff <= req_tdata[6*C_BITS+S_BITS +: COLOR_BITS];
      end
   end

   // Stage B: row range, edge choice and edge differences.
   logic [REG_BITS-1:0] hcl_in;
   logic signed [X_BITS-1:0] rs, lys, mys, hys, hs, ymin, ymid, ymax, ays;
   logic hit, lower;
   logic signed [C_BITS:0] dx1, dx2;
   logic signed [C_BITS-1:0] ax, bx, by;
   logic [C_BITS-1:0] adx1_in, adx2_in;

   always_comb begin
      hcl_in = (height_ff > SCREEN_LIM) ? SCREEN_LIM : height_ff;
      rs  = X_BITS'($signed({1'b0, ra_ff}));
      lys = X_BITS'(ly_ff);
      mys = X_BITS'(my_ff);
      hys = X_BITS'(hy_ff);
      hs  = X_BITS'($signed({1'b0, hcl_in}));
      ymin = (lys > 0) ? lys : '0;
      ymid = (mys < hs) ? mys : hs;
      if (ymid < 0) ymid = '0;
      ymax = (hys < hs) ? hys : hs;
      hit   = (rs >= ymin) && (rs < ymax);
      lower = (rs < ymid);
      ax  = lower ? lx_ff : mx_ff;
      ays = lower ? lys : mys;
      bx  = lower ? mx_ff : hx_ff;
      by  = lower ? my_ff : hy_ff;
      dx1 = (C_BITS+1)'(hx_ff) - (C_BITS+1)'(lx_ff);
      dx2 = (C_BITS+1)'(bx) - (C_BITS+1)'(ax);
      adx1_in = C_BITS'(dx1[C_BITS] ? -dx1 : dx1);
      adx2_in = C_BITS'(dx2[C_BITS] ? -dx2 : dx2);
   end

   logic vb_ff;
   logic [C_BITS-1:0] adx1_ff, t1_ff, dy1_ff, adx2_ff, t2_ff, dy2_ff;
   side_type sb_ff;

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (en) vb_ff <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adx1_ff <= adx1_in;
         t1_ff   <= C_BITS'(rs - lys);
         dy1_ff  <= C_BITS'(hys - lys);
         adx2_ff <= adx2_in;
         t2_ff   <= C_BITS'(rs - ays);
         dy2_ff  <= C_BITS'(X_BITS'(by) - ays);
         sb_ff.row   <= ra_ff;
         sb_ff.color <= ca_ff;
         sb_ff.hit   <= hit;
         sb_ff.neg1  <= dx1[C_BITS];
         sb_ff.neg2  <= dx2[C_BITS];
         sb_ff.base1 <= lx_ff;
         sb_ff.base2 <= ax;
      end
   end

   // Stage C: products of the x difference and the row offset.
   logic vc_ff;
   logic [2*C_BITS-1:0] q1_ff, q2_ff;
   logic [C_BITS-1:0] dy1c_ff, dy2c_ff;
   side_type sc_ff;

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (en) vc_ff <= vb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff   <= adx1_ff * t1_ff;
         q2_ff   <= adx2_ff * t2_ff;
         dy1c_ff <= dy1_ff;
         dy2c_ff <= dy2_ff;
         sc_ff   <= sb_ff;
      end
   end

   // Stage D: rounding dividend 2q+d over divisor 2d.
   logic vd_ff;
   logic [N_BITS-1:0] n1_ff, n2_ff;
   logic [D_BITS-1:0] d1_ff, d2_ff;
   side_type sd_ff;

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (en) vd_ff <= vc_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= N_BITS'({q1_ff, 1'b0}) + N_BITS'(dy1c_ff);
         n2_ff <= N_BITS'({q2_ff, 1'b0}) + N_BITS'(dy2c_ff);
         d1_ff <= {dy1c_ff, 1'b0};
         d2_ff <= {dy2c_ff, 1'b0};
         sd_ff <= sc_ff;
      end
   end

   // Division stages.
   logic [Q_BITS-1:0] quo1, quo2;

   tss_divider u_div1 (
      .clock  (clock),
      .en     (en),
      .num_in (n1_ff),
      .den_in (d1_ff),
      .quo_out(quo1)
   );

   tss_divider u_div2 (
      .clock  (clock),
      .en     (en),
      .num_in (n2_ff),
      .den_in (d2_ff),
      .quo_out(quo2)
   );

   logic     vq_ff [Q_BITS];
   side_type sq_ff [Q_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_BITS; k++) vq_ff[k] <= 1'b0;
      end else if (en) begin
         vq_ff[0] <= vd_ff;
         for (int k = 1; k < Q_BITS; k++) vq_ff[k] <= vq_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sd_ff;
         for (int k = 1; k < Q_BITS; k++) sq_ff[k] <= sq_ff[k-1];
      end
   end

   // Output stage: edge x values, ordering and clipping.
   side_type sf;
   logic [REG_BITS-1:0] wcl;
   logic signed [X_BITS-1:0] o1, o2, x1, x2, xa, xb, wm1;
   logic ok;

   always_comb begin
      sf  = sq_ff[Q_BITS-1];
      wcl = (width_ff > SCREEN_LIM) ? SCREEN_LIM : width_ff;
      wm1 = X_BITS'($signed({1'b0, wcl})) - X_BITS'(1);
      o1  = X_BITS'($signed({1'b0, quo1}));
      o2  = X_BITS'($signed({1'b0, quo2}));
      if (sf.neg1) o1 = -o1;
      if (sf.neg2) o2 = -o2;
      x1 = X_BITS'($signed(sf.base1)) + o1;
      x2 = X_BITS'($signed(sf.base2)) + o2;
      xa = (x1 < x2) ? x1 : x2;
      xb = (x1 < x2) ? x2 : x1;
      if (xa < 0) xa = '0;
      if (xb > wm1) xb = wm1;
      ok = sf.hit && (xa <= xb);
   end

   logic rsp_valid_ff;
   logic span_valid_ff;
   logic [S_BITS-1:0] span_row_ff, span_start_ff, span_end_ff;
   logic [COLOR_BITS-1:0] span_color_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= vq_ff[Q_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         span_valid_ff <= ok;
         span_row_ff   <= sf.row;
         span_start_ff <= ok ? S_BITS'(xa) : '0;
         span_end_ff   <= ok ? S_BITS'(xb) : '0;
         span_color_ff <= ok ? sf.color : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = span_valid_ff;
   assign rsp_tdata  = {4'd0, span_color_ff, span_end_ff, span_start_ff, span_row_ff};

endmodule
`default_nettype wire

// File: verif/triangle_scanline_span_tb.sv
// Self-checking testbench for the triangle scanline span block.
`default_nettype none
module triangle_scanline_span_tb
   import tss_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 400;

   typedef struct {
      logic signed [C_BITS-1:0] vx [3];
      logic signed [C_BITS-1:0] vy [3];
      logic [S_BITS-1:0]        row;
      logic [COLOR_BITS-1:0]    color;
   } tri_row_type;

   typedef struct {
      logic                  hit;
      logic [S_BITS-1:0]     row;
      logic [S_BITS-1:0]     first;
      logic [S_BITS-1:0]     last;
      logic [COLOR_BITS-1:0] color;
   } span_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [143:0]          req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [71:0]           rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_index = CSR_WIDTH;
   logic [REG_BITS-1:0]   csr_wdata = '0;

   tri_row_type pending_rows [$];
   span_type    expected_spans [$];
   tri_row_type row_on_bus;
   logic [REG_BITS-1:0] width_reg = WIDTH_RST;
   logic [REG_BITS-1:0] height_reg = HEIGHT_RST;
   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int stall_count = 0;
   int hold_left = 0;
   bit hold_go = 0;
   bit hold_used = 0;

   triangle_scanline_span DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint edge_step(longint dx, longint t, longint dy);
      longint adx, n;
      if (dy <= 0 || t < 0) return 0;
      adx = (dx < 0) ? -dx : dx;
      n = (2 * adx * t + dy) / (2 * dy);
      return (dx < 0) ? -n : n;
   endfunction

   // Sorts the vertices by the three strict compares and clips the row's span.
   function automatic span_type predict_span(tri_row_type it);
      span_type res;
      logic [2:0] sel;
      int lo, mi, hi;
      longint lx, ly, mx, my, hx, hy, w, h, r, ymin, ymid, ymax, x1, x2, xa, xb;
      sel = {it.vy[0] > it.vy[1], it.vy[0] > it.vy[2], it.vy[1] > it.vy[2]};
      case (sel)
         3'd0:    begin lo = 0; mi = 1; hi = 2; end
         3'd1:    begin lo = 0; mi = 2; hi = 1; end
         3'd3:    begin lo = 2; mi = 0; hi = 1; end
         3'd4:    begin lo = 1; mi = 0; hi = 2; end
         3'd6:    begin lo = 1; mi = 2; hi = 0; end
         3'd7:    begin lo = 2; mi = 1; hi = 0; end
         default: begin lo = 0; mi = 0; hi = 0; end
      endcase
      lx = longint'(it.vx[lo]); ly = longint'(it.vy[lo]);
      mx = longint'(it.vx[mi]); my = longint'(it.vy[mi]);
      hx = longint'(it.vx[hi]); hy = longint'(it.vy[hi]);
      w = longint'((width_reg > SCREEN_LIM) ? SCREEN_LIM : width_reg);
      h = longint'((height_reg > SCREEN_LIM) ? SCREEN_LIM : height_reg);
      r = longint'(it.row);
      ymin = (ly > 0) ? ly : 0;
      ymid = (my < h) ? my : h;
      if (ymid < 0) ymid = 0;
      ymax = (hy < h) ? hy : h;
      res = '{hit: 1'b0, row: it.row, first: '0, last: '0, color: '0};
      if (r >= ymin && r < ymax) begin
         x1 = lx + edge_step(hx - lx, r - ly, hy - ly);
         if (r < ymid) x2 = lx + edge_step(mx - lx, r - ly, my - ly);
         else x2 = mx + edge_step(hx - mx, r - my, hy - my);
         xa = (x1 < x2) ? x1 : x2;
         xb = (x1 < x2) ? x2 : x1;
         if (xa < 0) xa = 0;
         if (xb > w - 1) xb = w - 1;
         if (xa <= xb) begin
            res.hit = 1'b1;
            res.first = xa[S_BITS-1:0];
            res.last = xb[S_BITS-1:0];
            res.color = it.color;
         end
      end
      return res;
   endfunction

   // Driver: a new transaction is offered once the previous one has been taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) expected_spans.push_back(predict_span(row_on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle) begin
               row_on_bus <= pending_rows[0];
               req_tdata <= {4'b0, pending_rows[0].color, pending_rows[0].row,
                             pending_rows[0].vy[2], pending_rows[0].vx[2],
                             pending_rows[0].vy[1], pending_rows[0].vx[1],
                             pending_rows[0].vy[0], pending_rows[0].vx[0]};
               void'(pending_rows.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure, including one long hold-off while the sender keeps going.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic report(string what, longint want, longint got);
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
      errors++;
   endtask

   // Monitor: every result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      span_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_spans.size() == 0) begin
            report("unexpected span", 0, rsp_tdata[11:0]);
         end else begin
            want = expected_spans.pop_front();
            if (rsp_tuser[0] !== want.hit) report("span_valid", want.hit, rsp_tuser[0]);
            if (rsp_tdata[11:0] !== want.row) report("span_row", want.row, rsp_tdata[11:0]);
            if (rsp_tdata[23:12] !== want.first)
               report("span_start", want.first, rsp_tdata[23:12]);
            if (rsp_tdata[35:24] !== want.last)
               report("span_end", want.last, rsp_tdata[35:24]);
            if (rsp_tdata[67:36] !== want.color)
               report("span_color", want.color, rsp_tdata[67:36]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic tri_row_type make_row(int vx0, int vy0, int vx1, int vy1,
                                            int vx2, int vy2, int r, logic [31:0] c);
      tri_row_type it;
      it.vx[0] = C_BITS'(vx0); it.vy[0] = C_BITS'(vy0);
      it.vx[1] = C_BITS'(vx1); it.vy[1] = C_BITS'(vy1);
      it.vx[2] = C_BITS'(vx2); it.vy[2] = C_BITS'(vy2);
      it.row = S_BITS'(r);
      it.color = c;
      return it;
   endfunction

   // Mostly triangles around the visible screen, some over the whole coordinate range.
   function automatic tri_row_type random_row();
      tri_row_type it;
      int w, h;
      w = int'((width_reg > SCREEN_LIM) ? SCREEN_LIM : width_reg);
      h = int'((height_reg > SCREEN_LIM) ? SCREEN_LIM : height_reg);
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(9) == 0) begin
            it.vx[i] = C_BITS'($urandom);
            it.vy[i] = C_BITS'($urandom);
         end else begin
            it.vx[i] = C_BITS'(pick(-300, w + 300));
            it.vy[i] = C_BITS'(pick(-100, h + 100));
         end
      end
      if ($urandom_range(7) == 0) it.vy[$urandom_range(2)] = it.vy[$urandom_range(2)];
      it.row = ($urandom_range(5) == 0) ? S_BITS'($urandom)
                                        : S_BITS'(pick(0, (h > 0) ? h : 0));
      it.color = $urandom;
      return it;
   endfunction

   task automatic write_screen(int w, int h);
      while (pending_rows.size() > 0 || req_tvalid || expected_spans.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= REG_BITS'(w);
      width_reg = REG_BITS'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= REG_BITS'(h);
      height_reg = REG_BITS'(h);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int widths [6] = '{640, 4096, 8191, 1, 0, 300};
      int heights [6] = '{480, 4096, 1, 8191, 0, 200};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: every sort order, ties, flat edges and the coordinate extremes.
      pending_rows.push_back(make_row(100, 10, 300, 200, 50, 400, 100, 32'h1234_5678));
      pending_rows.push_back(make_row(100, 10, 50, 400, 300, 200, 300, 32'hffff_ffff));
      pending_rows.push_back(make_row(300, 200, 100, 10, 50, 400, 250, 32'h0));
      pending_rows.push_back(make_row(50, 400, 100, 10, 300, 200, 199, 32'h5555_aaaa));
      pending_rows.push_back(make_row(300, 200, 50, 400, 100, 10, 200, 32'haaaa_5555));
      pending_rows.push_back(make_row(50, 400, 300, 200, 100, 10, 10, 32'h0bad_cafe));
      pending_rows.push_back(make_row(0, 50, 600, 50, 300, 300, 50, 32'h1));
      pending_rows.push_back(make_row(0, 300, 600, 300, 300, 50, 299, 32'h2));
      pending_rows.push_back(make_row(0, 300, 600, 300, 300, 300, 300, 32'h3));
      pending_rows.push_back(make_row(-32768, -32768, 32767, -32768, 0, 32767, 0, 32'h4));
      pending_rows.push_back(make_row(-32768, -32768, 32767, 32767, -32768, 32767, 479,
                                      32'h5));
      pending_rows.push_back(make_row(32767, -32768, -32768, 32767, 32767, 32767, 4095,
                                      32'h6));
      pending_rows.push_back(make_row(-500, 0, -100, 100, -300, 479, 20, 32'h7));
      pending_rows.push_back(make_row(700, 0, 900, 100, 800, 479, 20, 32'h8));
      pending_rows.push_back(make_row(1, 0, 3, 4, 0, 9, 3, 32'h9));
      pending_rows.push_back(make_row(0, 0, 5, 2, 0, 4, 1, 32'ha));
      pending_rows.push_back(make_row(0, 0, -5, 2, 0, 4, 1, 32'hb));
      pending_rows.push_back(make_row(-100, -50, 800, 100, 200, 1000, 0, 32'hc));

      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_screen(widths[p], heights[p]);
         send_idle = (p < 2) ? 11 : (p < 4) ? 61 : 0;
         recv_idle = (p < 2) ? 61 : (p < 4) ? 11 : 0;
         for (int i = 0; i < 125; i++) pending_rows.push_back(random_row());
         if (p == 1) begin
            while (pending_rows.size() > 80) @(posedge clock);
            hold_go = 1'b1;
         end
      end

      while (pending_rows.size() > 0 || req_tvalid || expected_spans.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_divider.sv
hw/rtl/triangle_scanline_span.sv
verif/triangle_scanline_span_tb.sv
